// ----- src/rainbow_wave_hsv_pixel_generator_top_assert.svh -----
// Assertion macros for the rainbow wave pixel generator.
`ifndef RAINBOW_WAVE_HSV_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define RAINBOW_WAVE_HSV_PIXEL_GENERATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RWG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define RWG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RWG_ASSERT_IMP(lbl, ante, cons)

`define RWG_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- src/rwg_pkg.sv -----
package rwg_pkg;

  localparam int NUM_PIXELS  = 8;
  localparam int IDX_W       = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int FRAC_W      = $clog2(NUM_PIXELS) + 1;
  localparam int HUE_STEP    = 256 / NUM_PIXELS;
  localparam int HUE_FRAC    = 256 % NUM_PIXELS;
  localparam int REGION_SPAN = 43;
  localparam int REM_SCALE   = 6;

  localparam int IN_W      = 8;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LEVEL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_STEP = 8'd2;

  localparam logic [7:0] SAT_RESET  = 8'd255;
  localparam logic [7:0] VAL_RESET  = 8'd255;
  localparam logic [7:0] STEP_RESET = 8'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef enum logic [2:0] {
    RGN_0,
    RGN_1,
    RGN_2,
    RGN_3,
    RGN_4,
    RGN_5
  } region_e;

  typedef struct packed {
    logic start;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic at_last;
    logic pipe_empty;
  } sts_t;

  typedef struct packed {
    region_e    region;
    logic [7:0] rem;
  } hue_split_t;

  function automatic hue_split_t hue_split(logic [7:0] hue);
    hue_split_t s;
    logic [7:0] base;
    if (hue >= 8'(5 * REGION_SPAN)) begin
      s.region = RGN_5;
      base     = 8'(5 * REGION_SPAN);
    end else if (hue >= 8'(4 * REGION_SPAN)) begin
      s.region = RGN_4;
      base     = 8'(4 * REGION_SPAN);
    end else if (hue >= 8'(3 * REGION_SPAN)) begin
      s.region = RGN_3;
      base     = 8'(3 * REGION_SPAN);
    end else if (hue >= 8'(2 * REGION_SPAN)) begin
      s.region = RGN_2;
      base     = 8'(2 * REGION_SPAN);
    end else if (hue >= 8'(REGION_SPAN)) begin
      s.region = RGN_1;
      base     = 8'(REGION_SPAN);
    end else begin
      s.region = RGN_0;
      base     = 8'd0;
    end
    s.rem = 8'((hue - base) * REM_SCALE);
    return s;
  endfunction

endpackage

// ----- src/rwg_ctrl.sv -----
module rwg_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_req_i,
  output logic        start_rdy_o,
  input  rwg_pkg::sts_t sts_i,
  output rwg_pkg::cmd_t cmd_o
);
  import rwg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_req_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.adv && sts_i.at_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    start_rdy_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        start_rdy_o = 1'b1;
        cmd_o.start = start_req_i;
      end
      ST_RUN: begin
        cmd_o.issue = sts_i.adv;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/rwg_datapath.sv -----
module rwg_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rwg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rwg_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  rwg_pkg::cmd_t                    cmd_i,
  output rwg_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rwg_pkg::OUT_W-1:0]        out_data_o,
  output logic                             out_last_o
);
  import rwg_pkg::*;

  logic [7:0] sat_q, val_q, step_q, offset_q;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [7:0]        base_q, base_d;
  logic [7:0]        frac_sum;
  logic              at_last, adv;

  logic              v1_q, v2_q, v3_q, vo_q;
  region_e           rg1_q, rg2_q, rg3_q;
  logic [IDX_W-1:0]  ix1_q, ix2_q, ix3_q;
  logic              l1_q, l2_q, l3_q;
  logic [7:0]        rem1_q;
  logic [7:0]        sr2_q, srn2_q, ps2_q;
  logic [7:0]        p3_q, q3_q, t3_q;
  logic [OUT_W-1:0]  data_q;
  logic              last_q;

  hue_split_t        split;
  logic [15:0]       m_sr, m_srn, m_p, m_q, m_t;
  logic [7:0]        r_c, g_c, b_c;

  assign adv     = !vo_q || out_ready_i;
  assign at_last = (idx_q == IDX_W'(NUM_PIXELS - 1));

  assign sts_o.adv        = adv;
  assign sts_o.at_last    = at_last;
  assign sts_o.pipe_empty = !(v1_q || v2_q || v3_q || vo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q  <= SAT_RESET;
      val_q  <= VAL_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SATURATION:  sat_q  <= cfg_data_i;
        CFG_VALUE_LEVEL: val_q  <= cfg_data_i;
        CFG_OFFSET_STEP: step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign frac_sum = 8'(frac_q) + 8'(HUE_FRAC);

  always_comb begin
    idx_d  = idx_q;
    frac_d = frac_q;
    base_d = base_q;
    if (cmd_i.start) begin
      idx_d  = '0;
      frac_d = '0;
      base_d = '0;
    end else if (cmd_i.issue) begin
      idx_d = idx_q + IDX_W'(1);
      if (frac_sum >= 8'(NUM_PIXELS)) begin
        frac_d = FRAC_W'(frac_sum - 8'(NUM_PIXELS));
        base_d = base_q + 8'(HUE_STEP) + 8'd1;
      end else begin
        frac_d = FRAC_W'(frac_sum);
        base_d = base_q + 8'(HUE_STEP);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      frac_q   <= '0;
      base_q   <= '0;
      offset_q <= '0;
    end else begin
      idx_q  <= idx_d;
      frac_q <= frac_d;
      base_q <= base_d;
      if (cmd_i.issue && at_last) offset_q <= offset_q + step_q;
    end
  end

  assign split = hue_split(base_q + offset_q);
  assign m_sr  = 16'(sat_q) * 16'(rem1_q);
  assign m_srn = 16'(sat_q) * 16'(8'd255 - rem1_q);
  assign m_p   = 16'(val_q) * 16'(ps2_q);
  assign m_q   = 16'(val_q) * 16'(8'd255 - sr2_q);
  assign m_t   = 16'(val_q) * 16'(8'd255 - srn2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rg1_q  <= split.region;
      rem1_q <= split.rem;
      ix1_q  <= idx_q;
      l1_q   <= at_last;

      rg2_q  <= rg1_q;
      ix2_q  <= ix1_q;
      l2_q   <= l1_q;
      sr2_q  <= m_sr[15:8];
      srn2_q <= m_srn[15:8];
      ps2_q  <= 8'd255 - sat_q;

      rg3_q  <= rg2_q;
      ix3_q  <= ix2_q;
      l3_q   <= l2_q;
      p3_q   <= m_p[15:8];
      q3_q   <= m_q[15:8];
      t3_q   <= m_t[15:8];

      data_q <= {5'd0, b_c, g_c, r_c, 3'(ix3_q)};
      last_q <= l3_q;
    end
  end

  always_comb begin
    case (rg3_q)
      RGN_0:   begin r_c = val_q; g_c = t3_q;  b_c = p3_q;  end
      RGN_1:   begin r_c = q3_q;  g_c = val_q; b_c = p3_q;  end
      RGN_2:   begin r_c = p3_q;  g_c = val_q; b_c = t3_q;  end
      RGN_3:   begin r_c = p3_q;  g_c = q3_q;  b_c = val_q; end
      RGN_4:   begin r_c = t3_q;  g_c = p3_q;  b_c = val_q; end
      default: begin r_c = val_q; g_c = p3_q;  b_c = q3_q;  end
    endcase
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

// ----- src/rainbow_wave_hsv_pixel_generator_top.sv -----
// Rainbow wave pixel generator.
// Input stream: one item per frame request; s_axis_tdata[0] is frame_tick.
// An item with frame_tick low is taken and produces nothing.
// Output stream: one item per ring pixel, in index order, tlast on the
// final pixel. Pixel i has hue i*256/NUM_PIXELS plus the wave offset, mod 256,
// converted with the six-region integer HSV-to-RGB scheme.
// Config channel: index 0 saturation, 1 value level, 2 offset step; other
// indexes are ignored. Write only while no frame is in flight.
// Once a request is taken, the controller issues one pixel per cycle while
// m_axis_tready does not stall the output; each pixel passes through the
// 4-stage conversion pipeline (region split, saturation products, value
// products, output register). After the last issue the controller waits until
// the pipeline is empty and returns to idle; only then is a new request taken.
// A stall on m_axis_tready freezes the whole pipeline; nothing is lost.
// Reset: saturation 255, value 255, step 2, wave offset 0; the offset
// advances by the step after each frame.
`include "rainbow_wave_hsv_pixel_generator_top_assert.svh"

module rainbow_wave_hsv_pixel_generator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] frame_tick, [7:1] zero
  input  logic [rwg_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] pixel_index, [10:3] red, [18:11] green, [26:19] blue, [31:27] zero
  output logic [rwg_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rwg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rwg_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import rwg_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic start_req;

  assign cfg_ready_o = 1'b1;
  assign start_req   = s_axis_tvalid && s_axis_tdata[0];

  rwg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_req_i (start_req),
    .start_rdy_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rwg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  `RWG_ASSERT_IMP(a_idle_no_output, s_axis_tready, !m_axis_tvalid)
  `RWG_ASSERT_IMP(a_last_index, m_axis_tvalid && m_axis_tlast,
                  m_axis_tdata[2:0] == 3'(NUM_PIXELS - 1))
  `RWG_ASSERT_NXT(a_no_start_mid_frame,
                  m_axis_tvalid && m_axis_tready && !m_axis_tlast, !s_axis_tready)
  `RWG_ASSERT_IMP(a_issue_busy, cmd.issue, !s_axis_tready)

endmodule

// ----- sim/rainbow_wave_hsv_pixel_generator_top_tb.sv -----
`timescale 1ns / 1ps

module rainbow_wave_hsv_pixel_generator_top_tb;

  import rwg_pkg::*;

  localparam int SETTLE         = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_FRAMES  = 200;
  localparam int REPORT_CAP     = 50;

  typedef struct {
    logic [2:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  class ring_scoreboard;
    logic [7:0] sat_q;
    logic [7:0] val_q;
    logic [7:0] step_q;
    logic [7:0] offset_q;
    pixel_t     pixels_due[$];
    int         errors;
    int         frames;
    int         empty_reqs;
    int         pixels_seen;
    logic [5:0] regions_hit;

    function new();
      sat_q       = SAT_RESET;
      val_q       = VAL_RESET;
      step_q      = STEP_RESET;
      offset_q    = 8'd0;
      errors      = 0;
      frames      = 0;
      empty_reqs  = 0;
      pixels_seen = 0;
      regions_hit = '0;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] data);
      case (idx)
        CFG_SATURATION:  sat_q  = data;
        CFG_VALUE_LEVEL: val_q  = data;
        CFG_OFFSET_STEP: step_q = data;
        default: ;
      endcase
    endfunction

    function pixel_t shade(int unsigned hue, int unsigned pos);
      int unsigned seg;
      int unsigned frac;
      int unsigned sat;
      int unsigned val;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      region_e     rgn;
      pixel_t      px;
      sat  = sat_q;
      val  = val_q;
      seg  = hue / 43;
      frac = (hue - seg * 43) * 6;
      p    = (val * (255 - sat)) >> 8;
      q    = (val * (255 - ((sat * frac) >> 8))) >> 8;
      t    = (val * (255 - ((sat * (255 - frac)) >> 8))) >> 8;
      rgn  = region_e'(seg);
      regions_hit[seg] = 1'b1;
      case (rgn)
        RGN_0: begin
          px.red = 8'(val); px.green = 8'(t); px.blue = 8'(p);
        end
        RGN_1: begin
          px.red = 8'(q); px.green = 8'(val); px.blue = 8'(p);
        end
        RGN_2: begin
          px.red = 8'(p); px.green = 8'(val); px.blue = 8'(t);
        end
        RGN_3: begin
          px.red = 8'(p); px.green = 8'(q); px.blue = 8'(val);
        end
        RGN_4: begin
          px.red = 8'(t); px.green = 8'(p); px.blue = 8'(val);
        end
        default: begin
          px.red = 8'(val); px.green = 8'(p); px.blue = 8'(q);
        end
      endcase
      px.index = 3'(pos);
      px.last  = (pos == NUM_PIXELS - 1);
      return px;
    endfunction

    function void note_frame(logic tick);
      int unsigned hue;
      if (tick !== 1'b1) begin
        empty_reqs++;
        return;
      end
      for (int unsigned i = 0; i < NUM_PIXELS; i++) begin
        hue = ((i * 256) / NUM_PIXELS + offset_q) & 8'hFF;
        pixels_due.push_back(shade(hue, i));
      end
      offset_q = offset_q + step_q;
      frames++;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= REPORT_CAP) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endtask

    task check_pixel(logic [OUT_W-1:0] data, logic last_bit);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("pixel with nothing due, tdata %h", data));
        return;
      end
      want = pixels_due.pop_front();
      pixels_seen++;
      if (data[2:0] !== want.index)
        report_mismatch($sformatf("pixel_index %0d, want %0d", data[2:0], want.index));
      if (data[10:3] !== want.red)
        report_mismatch($sformatf("pixel %0d red %0d, want %0d",
                                  want.index, data[10:3], want.red));
      if (data[18:11] !== want.green)
        report_mismatch($sformatf("pixel %0d green %0d, want %0d",
                                  want.index, data[18:11], want.green));
      if (data[26:19] !== want.blue)
        report_mismatch($sformatf("pixel %0d blue %0d, want %0d",
                                  want.index, data[26:19], want.blue));
      if (data[OUT_W-1:27] !== '0)
        report_mismatch($sformatf("pixel %0d pad bits %h", want.index, data[OUT_W-1:27]));
      if (last_bit !== want.last)
        report_mismatch($sformatf("pixel %0d tlast %b, want %b",
                                  want.index, last_bit, want.last));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  ring_scoreboard sb;
  bit             sink_stalls;
  int             quiet_cycles;
  int             reg_writes;
  int             stall_phases;

  rainbow_wave_hsv_pixel_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // monitor all three channels at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_frame(s_axis_tdata[0]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_pixel(m_axis_tdata, m_axis_tlast);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_reg(cfg_index_i, cfg_data_i);
        reg_writes++;
      end
    end
  end

  initial begin : sink
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!sink_stalls || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        n = pick_gap() + 1;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic send_request(input logic tick);
    s_axis_tdata  <= {{(IN_W-1){1'b0}}, tick};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic hold_sender(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold until every pixel is out and the pipeline is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic frame_then_gap(input logic tick);
    send_request(tick);
    hold_sender(pick_gap());
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    bit sender_gaps;
    sb            = new();
    sink_stalls   = 1'b1;
    reg_writes    = 0;
    stall_phases  = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    frame_then_gap(1'b1);
    frame_then_gap(1'b0);
    frame_then_gap(1'b1);
    drain();
    write_reg(CFG_SATURATION, 8'd0);
    frame_then_gap(1'b1);
    drain();
    write_reg(CFG_SATURATION, 8'd255);
    write_reg(CFG_VALUE_LEVEL, 8'd0);
    frame_then_gap(1'b1);
    drain();
    write_reg(CFG_SATURATION, 8'd128);
    write_reg(CFG_VALUE_LEVEL, 8'd255);
    write_reg(CFG_OFFSET_STEP, 8'd255);
    frame_then_gap(1'b1);
    frame_then_gap(1'b1);
    drain();
    write_reg(CFG_OFFSET_STEP, 8'd0);
    send_request(1'b1);
    send_request(1'b1);
    drain();
    write_reg(8'd3, 8'hAA);
    write_reg(8'd255, 8'h55);
    write_reg(CFG_OFFSET_STEP, 8'd31);
    frame_then_gap(1'b1);
    frame_then_gap(1'b0);
    frame_then_gap(1'b1);
    drain();

    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      if ($urandom_range(0, 1)) write_reg(CFG_SATURATION, pick_byte());
      if ($urandom_range(0, 1)) write_reg(CFG_VALUE_LEVEL, pick_byte());
      if ($urandom_range(0, 1)) write_reg(CFG_OFFSET_STEP, pick_byte());
      if ($urandom_range(0, 5) == 0)
        write_reg(8'($urandom_range(3, 255)), 8'($urandom_range(0, 255)));
      sink_stalls = ($urandom_range(0, 3) != 0);
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (sink_stalls) stall_phases++;
      burst = $urandom_range(10, 30);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(1'b0);
        end else begin
          send_request(1'b1);
          sent++;
        end
        if ($urandom_range(0, 24) == 0) drain();
        else if (sender_gaps) hold_sender(pick_gap());
      end
      drain();
    end

    $display("covered %0d frames and %0d empty requests, %0d pixels checked",
             sb.frames, sb.empty_reqs, sb.pixels_seen);
    $display("%0d register writes, hue regions reached %b, %0d phases with output stalls",
             reg_writes, sb.regions_hit, stall_phases);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d pixels still due", sb.errors, sb.pending());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
